FILE: sv/buddy_page_frame_allocator_assert.svh
// ----------------------------------------------------------------------------
// Buddy page frame allocator: assertion macros
// Shared macros for the concurrent checks on the allocator ports.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BPFA_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bpfa: port check failed");

// Next-cycle implication, disabled while reset is asserted
`define BPFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bpfa: port check failed");

`endif

FILE: sv/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page frame allocator: package
// Sizes, codes, memory entry formats and request structs shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

    // Frame space (a power of two that the 16-bit frame fields cover)
    localparam int NUM_FRAMES = 65536;
    localparam int MAX_ORDER  = 20;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int ORD_W      = 5;

    // Free bitmap geometry: one 64-bit word per 64 frames, per order
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORDS      = NUM_FRAMES / WORD_BITS;
    localparam int WORD_W     = $clog2(WORDS);
    localparam int BM_DEPTH   = MAX_ORDER * WORDS;
    localparam int BM_AW      = ORD_W + WORD_W;

    // Highest order the build pass merges up to
    localparam int TOP_LVL    = (MAX_ORDER - 1 < FRAME_W) ? MAX_ORDER - 1 : FRAME_W;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_RESERVE = 2'd0,
        KIND_BUILD   = 2'd1,
        KIND_ALLOC   = 2'd2,
        KIND_FREE    = 2'd3
    } t_kind;

    // Result status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_PHASE = 2'd2;

    // Frame marks
    localparam logic [1:0] MK_ROOT     = 2'd0;
    localparam logic [1:0] MK_ABSORBED = 2'd1;
    localparam logic [1:0] MK_USED     = 2'd2;

    // One frame table entry
    typedef struct packed {
        logic [1:0]       mark;
        logic [ORD_W-1:0] order;
    } t_frame_ent;

    // Frame table access: two read ports, one write port
    typedef struct packed {
        logic               re;
        logic [FRAME_W-1:0] ra;
        logic [FRAME_W-1:0] rb;
        logic               we;
        logic [FRAME_W-1:0] wa;
        t_frame_ent         wd;
    } t_frm_req;

    // Free bitmap access: one read port, one write port
    typedef struct packed {
        logic                 re;
        logic [BM_AW-1:0]     raddr;
        logic                 we;
        logic [BM_AW-1:0]     waddr;
        logic [WORD_BITS-1:0] wd;
    } t_bm_req;

    // Finished result from the sequencer
    typedef struct packed {
        logic               valid;
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic [ORD_W-1:0]   order;
    } t_res;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RSV,
        S_BLD_RD, S_BLD_CHK, S_BLD_WL,
        S_FIL_RD, S_FIL_CHK, S_FIL_WR,
        S_AL_RD, S_AL_CHK, S_AL_POS, S_SP_RD, S_SP_WR,
        S_FR_RD, S_FR_CHK, S_FR_SET,
        S_MG_TOP, S_MG_CHK, S_MG_C1W, S_MG_C2, S_MG_C2W, S_MG_S, S_MG_SW,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

FILE: sv/bpfa_frame_mem.sv
// ----------------------------------------------------------------------------
// Buddy page frame allocator: frame table
// Mark and order of every frame; two registered read ports, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_frame_mem (
    input  wire logic                  i_clk,
    input  wire bpfa_pkg::t_frm_req    i_req,
    output bpfa_pkg::t_frame_ent       o_rda,
    output bpfa_pkg::t_frame_ent       o_rdb
);
    import bpfa_pkg::*;

    t_frame_ent mem [NUM_FRAMES];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wa] <= i_req.wd;
        end
    end

    // Read two entries, hold the data between reads
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rda <= mem[i_req.ra];
            o_rdb <= mem[i_req.rb];
        end
    end

endmodule

`default_nettype wire

FILE: sv/bpfa_bitmap_mem.sv
// ----------------------------------------------------------------------------
// Buddy page frame allocator: free bitmap
// One 64-bit word per order and 64 frames; registered read, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_bitmap_mem (
    input  wire logic                                i_clk,
    input  wire bpfa_pkg::t_bm_req                   i_req,
    output logic [bpfa_pkg::WORD_BITS-1:0]           o_rd
);
    import bpfa_pkg::*;

    logic [WORD_BITS-1:0] mem [BM_DEPTH];

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wd;
        end
    end

    // Read one word, hold the data between reads
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rd <= mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy page frame allocator: sequencer
// Walks the frame table and free bitmap with read-modify-write steps for
// clear, reserve, build, allocate and free requests.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_kind,
    input  wire logic [15:0]                        i_first_frame,
    input  wire logic [15:0]                        i_last_frame,
    input  wire logic [16:0]                        i_frames_wanted,
    output bpfa_pkg::t_frm_req                      o_frm,
    input  wire bpfa_pkg::t_frame_ent               i_frm_rda,
    input  wire bpfa_pkg::t_frame_ent               i_frm_rdb,
    output bpfa_pkg::t_bm_req                       o_bm,
    input  wire logic [bpfa_pkg::WORD_BITS-1:0]     i_bm_rd,
    output bpfa_pkg::t_res                          o_res,
    input  wire logic                               i_res_take
);
    import bpfa_pkg::*;

    // Order needed for a request of n frames (zero counts as one)
    function automatic logic [ORD_W-1:0] f_ceil_log2(input logic [16:0] n);
        logic [16:0]      v;
        logic [ORD_W-1:0] r;
        v = n - 17'd1;
        r = '0;
        if (n > 17'd1) begin
            for (int i = 0; i < 17; i++) begin
                if (v[i]) r = ORD_W'(i + 1);
            end
        end
        return r;
    endfunction

    // Index of the lowest set bit of a bitmap word
    function automatic logic [BIT_W-1:0] f_lowest(input logic [WORD_BITS-1:0] d);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (d[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    t_state               r_state, n_state;
    logic [FRAME_W-1:0]   r_cnt, n_cnt;
    logic [FRAME_W-1:0]   r_last, n_last;
    logic [ORD_W-1:0]     r_lvl, n_lvl;
    logic [FRAME_W-1:0]   r_j, n_j;
    logic [ORD_W-1:0]     r_ord, n_ord;
    logic [ORD_W-1:0]     r_sz, n_sz;
    logic [WORD_W-1:0]    r_w, n_w;
    logic [FRAME_W-1:0]   r_pos, n_pos;
    logic                 r_built, n_built;
    logic [1:0]           r_status, n_status;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [ORD_W-1:0]     r_order, n_order;

    t_kind                kind;
    logic [ORD_W-1:0]     want_ord;
    logic [FRAME_W-1:0]   bld_half;
    logic [FRAME_W:0]     bld_full;
    logic [FRAME_W-1:0]   bld_r;
    logic                 bld_last;
    logic                 bld_pair;
    logic [BIT_W-1:0]     al_bit;
    logic [ORD_W-1:0]     sp_ord;
    logic [FRAME_W-1:0]   sp_pt;
    logic [FRAME_W:0]     mg_blk;
    logic [FRAME_W-1:0]   mg_l;
    logic [FRAME_W:0]     mg_r;
    logic                 mg_pair;
    logic                 mg_same;

    // Hold state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_built <= n_built;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_lvl    <= n_lvl;
        r_j      <= n_j;
        r_ord    <= n_ord;
        r_sz     <= n_sz;
        r_w      <= n_w;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_frame  <= n_frame;
        r_order  <= n_order;
    end

    // Derive addresses for the current step
    always_comb begin
        kind     = t_kind'(i_kind);
        want_ord = f_ceil_log2(i_frames_wanted);
        bld_half = FRAME_W'(1) << (r_lvl - ORD_W'(1));
        bld_full = (FRAME_W + 1)'(1) << r_lvl;
        bld_r    = r_j + bld_half;
        bld_last = (r_j == FRAME_W'((FRAME_W + 1)'(NUM_FRAMES) - bld_full));
        bld_pair = (i_frm_rda.mark == MK_ROOT) && (i_frm_rdb.mark == MK_ROOT) &&
                   (i_frm_rda.order == r_lvl - ORD_W'(1)) &&
                   (i_frm_rdb.order == r_lvl - ORD_W'(1));
        al_bit   = f_lowest(i_bm_rd);
        sp_ord   = (r_state == S_SP_RD) ? r_ord - ORD_W'(1) : r_ord;
        sp_pt    = r_pos + (FRAME_W'(1) << sp_ord);
        mg_blk   = (FRAME_W + 1)'(1) << r_ord;
        mg_l     = r_pos & ~mg_blk[FRAME_W-1:0];
        mg_r     = {1'b0, mg_l} + mg_blk;
        mg_pair  = (i_frm_rda.mark == MK_ROOT) && (i_frm_rdb.mark == MK_ROOT) &&
                   (i_frm_rda.order == r_ord) && (i_frm_rdb.order == r_ord);
        mg_same  = (mg_l[FRAME_W-1:BIT_W] == mg_r[FRAME_W-1:BIT_W]);
    end

    // Sequence the memory steps of each request
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_lvl    = r_lvl;
        n_j      = r_j;
        n_ord    = r_ord;
        n_sz     = r_sz;
        n_w      = r_w;
        n_pos    = r_pos;
        n_built  = r_built;
        n_status = r_status;
        n_frame  = r_frame;
        n_order  = r_order;
        o_frm    = '0;
        o_bm     = '0;

        unique case (r_state)
            // Sweep both memories to their reset contents
            S_CLEAR: begin
                o_frm.we    = 1'b1;
                o_frm.wa    = r_cnt;
                o_frm.wd    = '{mark: MK_ROOT, order: '0};
                o_bm.we     = (r_cnt < FRAME_W'(BM_DEPTH));
                o_bm.waddr  = r_cnt[BM_AW-1:0];
                o_bm.wd     = '0;
                if (r_cnt == FRAME_W'(NUM_FRAMES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + FRAME_W'(1);
                end
            end

            // Take a request and pick its sequence
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = STAT_DONE;
                    n_frame  = '0;
                    n_order  = '0;
                    unique case (kind)
                        KIND_RESERVE: begin
                            if (r_built) begin
                                n_status = STAT_PHASE;
                                n_state  = S_RESP;
                            end else if (i_first_frame > i_last_frame) begin
                                n_state = S_RESP;
                            end else begin
                                n_cnt   = i_first_frame;
                                n_last  = i_last_frame;
                                n_state = S_RSV;
                            end
                        end
                        KIND_BUILD: begin
                            if (r_built) begin
                                n_status = STAT_PHASE;
                                n_state  = S_RESP;
                            end else begin
                                n_lvl   = ORD_W'(1);
                                n_j     = '0;
                                n_cnt   = '0;
                                n_state = (TOP_LVL >= 1) ? S_BLD_RD : S_FIL_RD;
                            end
                        end
                        KIND_ALLOC: begin
                            if (!r_built) begin
                                n_status = STAT_PHASE;
                                n_state  = S_RESP;
                            end else if (want_ord >= ORD_W'(MAX_ORDER)) begin
                                n_status = STAT_NOFIT;
                                n_state  = S_RESP;
                            end else begin
                                n_sz    = want_ord;
                                n_ord   = want_ord;
                                n_w     = '0;
                                n_state = S_AL_RD;
                            end
                        end
                        KIND_FREE: begin
                            if (!r_built) begin
                                n_status = STAT_PHASE;
                                n_state  = S_RESP;
                            end else begin
                                n_pos   = i_first_frame;
                                n_state = S_FR_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            // Mark reserved frames one per cycle
            S_RSV: begin
                o_frm.we = 1'b1;
                o_frm.wa = r_cnt;
                o_frm.wd = '{mark: MK_USED, order: '0};
                if (r_cnt == r_last) begin
                    n_state = S_RESP;
                end else begin
                    n_cnt = r_cnt + FRAME_W'(1);
                end
            end

            // Build: read a buddy pair at the current level
            S_BLD_RD: begin
                o_frm.re = 1'b1;
                o_frm.ra = r_j;
                o_frm.rb = bld_r;
                n_state  = S_BLD_CHK;
            end

            // Build: absorb the upper buddy and promote the lower one, or advance
            S_BLD_CHK, S_BLD_WL: begin
                if (r_state == S_BLD_CHK && bld_pair) begin
                    o_frm.we = 1'b1;
                    o_frm.wa = bld_r;
                    o_frm.wd = '{mark: MK_ABSORBED, order: i_frm_rdb.order};
                    n_state  = S_BLD_WL;
                end else begin
                    if (r_state == S_BLD_WL) begin
                        o_frm.we = 1'b1;
                        o_frm.wa = r_j;
                        o_frm.wd = '{mark: MK_ROOT, order: r_lvl};
                    end
                    if (!bld_last) begin
                        n_j     = r_j + FRAME_W'(bld_full);
                        n_state = S_BLD_RD;
                    end else if (r_lvl == ORD_W'(TOP_LVL)) begin
                        n_cnt   = '0;
                        n_state = S_FIL_RD;
                    end else begin
                        n_lvl   = r_lvl + ORD_W'(1);
                        n_j     = '0;
                        n_state = S_BLD_RD;
                    end
                end
            end

            // Fill: read one frame
            S_FIL_RD: begin
                o_frm.re = 1'b1;
                o_frm.ra = r_cnt;
                n_state  = S_FIL_CHK;
            end

            // Fill: set the bitmap bit of a free root, or advance
            S_FIL_CHK, S_FIL_WR: begin
                if (r_state == S_FIL_CHK && i_frm_rda.mark == MK_ROOT &&
                    i_frm_rda.order < ORD_W'(MAX_ORDER)) begin
                    o_bm.re    = 1'b1;
                    o_bm.raddr = {i_frm_rda.order, r_cnt[FRAME_W-1:BIT_W]};
                    n_ord      = i_frm_rda.order;
                    n_state    = S_FIL_WR;
                end else begin
                    if (r_state == S_FIL_WR) begin
                        o_bm.we    = 1'b1;
                        o_bm.waddr = {r_ord, r_cnt[FRAME_W-1:BIT_W]};
                        o_bm.wd    = i_bm_rd | (WORD_BITS'(1) << r_cnt[BIT_W-1:0]);
                    end
                    if (r_cnt == FRAME_W'(NUM_FRAMES - 1)) begin
                        n_built = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_cnt   = r_cnt + FRAME_W'(1);
                        n_state = S_FIL_RD;
                    end
                end
            end

            // Allocate: scan bitmap words from the lowest address up
            S_AL_RD: begin
                o_bm.re    = 1'b1;
                o_bm.raddr = {r_ord, r_w};
                n_state    = S_AL_CHK;
            end

            S_AL_CHK: begin
                if (i_bm_rd != '0) begin
                    o_bm.we    = 1'b1;
                    o_bm.waddr = {r_ord, r_w};
                    o_bm.wd    = i_bm_rd & ~(WORD_BITS'(1) << al_bit);
                    o_frm.re   = 1'b1;
                    o_frm.ra   = {r_w, al_bit};
                    n_pos      = {r_w, al_bit};
                    n_state    = S_AL_POS;
                end else if (r_w != WORD_W'(WORDS - 1)) begin
                    n_w     = r_w + WORD_W'(1);
                    n_state = S_AL_RD;
                end else if (r_ord != ORD_W'(MAX_ORDER - 1)) begin
                    n_ord   = r_ord + ORD_W'(1);
                    n_w     = '0;
                    n_state = S_AL_RD;
                end else begin
                    n_status = STAT_NOFIT;
                    n_state  = S_RESP;
                end
            end

            // Allocate: grant at once or start splitting
            S_AL_POS: begin
                if (r_ord > r_sz) begin
                    n_state = S_SP_RD;
                end else begin
                    o_frm.we = 1'b1;
                    o_frm.wa = r_pos;
                    o_frm.wd = '{mark: MK_USED, order: i_frm_rda.order};
                    n_frame  = r_pos;
                    n_order  = r_sz;
                    n_state  = S_RESP;
                end
            end

            // Split: free the upper half at one order lower
            S_SP_RD: begin
                o_frm.we   = 1'b1;
                o_frm.wa   = sp_pt;
                o_frm.wd   = '{mark: MK_ROOT, order: sp_ord};
                o_bm.re    = 1'b1;
                o_bm.raddr = {sp_ord, sp_pt[FRAME_W-1:BIT_W]};
                n_ord      = sp_ord;
                n_state    = S_SP_WR;
            end

            S_SP_WR: begin
                o_bm.we    = 1'b1;
                o_bm.waddr = {r_ord, sp_pt[FRAME_W-1:BIT_W]};
                o_bm.wd    = i_bm_rd | (WORD_BITS'(1) << sp_pt[BIT_W-1:0]);
                if (r_ord > r_sz) begin
                    n_state = S_SP_RD;
                end else begin
                    o_frm.we = 1'b1;
                    o_frm.wa = r_pos;
                    o_frm.wd = '{mark: MK_USED, order: r_sz};
                    n_frame  = r_pos;
                    n_order  = r_sz;
                    n_state  = S_RESP;
                end
            end

            // Free: check the frame
            S_FR_RD: begin
                o_frm.re = 1'b1;
                o_frm.ra = r_pos;
                n_state  = S_FR_CHK;
            end

            S_FR_CHK: begin
                if (i_frm_rda.mark != MK_USED || i_frm_rda.order >= ORD_W'(MAX_ORDER)) begin
                    n_state = S_RESP;
                end else begin
                    o_frm.we   = 1'b1;
                    o_frm.wa   = r_pos;
                    o_frm.wd   = '{mark: MK_ROOT, order: i_frm_rda.order};
                    o_bm.re    = 1'b1;
                    o_bm.raddr = {i_frm_rda.order, r_pos[FRAME_W-1:BIT_W]};
                    n_ord      = i_frm_rda.order;
                    n_state    = S_FR_SET;
                end
            end

            S_FR_SET: begin
                o_bm.we    = 1'b1;
                o_bm.waddr = {r_ord, r_pos[FRAME_W-1:BIT_W]};
                o_bm.wd    = i_bm_rd | (WORD_BITS'(1) << r_pos[BIT_W-1:0]);
                n_state    = S_MG_TOP;
            end

            // Merge: read both buddies unless the ceiling or the end is hit
            S_MG_TOP: begin
                if (r_ord + ORD_W'(1) >= ORD_W'(MAX_ORDER) ||
                    mg_r >= (FRAME_W + 1)'(NUM_FRAMES)) begin
                    n_order = r_ord;
                    n_state = S_RESP;
                end else begin
                    o_frm.re = 1'b1;
                    o_frm.ra = mg_l;
                    o_frm.rb = mg_r[FRAME_W-1:0];
                    n_state  = S_MG_CHK;
                end
            end

            S_MG_CHK: begin
                if (mg_pair) begin
                    o_frm.we   = 1'b1;
                    o_frm.wa   = mg_r[FRAME_W-1:0];
                    o_frm.wd   = '{mark: MK_ABSORBED, order: r_ord};
                    o_bm.re    = 1'b1;
                    o_bm.raddr = {r_ord, mg_l[FRAME_W-1:BIT_W]};
                    n_state    = S_MG_C1W;
                end else begin
                    n_order = r_ord;
                    n_state = S_RESP;
                end
            end

            // Merge: drop both halves from the lower order
            S_MG_C1W: begin
                o_bm.we    = 1'b1;
                o_bm.waddr = {r_ord, mg_l[FRAME_W-1:BIT_W]};
                o_bm.wd    = i_bm_rd & ~(WORD_BITS'(1) << mg_l[BIT_W-1:0]);
                if (mg_same) begin
                    o_bm.wd = o_bm.wd & ~(WORD_BITS'(1) << mg_r[BIT_W-1:0]);
                end
                o_frm.we   = 1'b1;
                o_frm.wa   = mg_l;
                o_frm.wd   = '{mark: MK_ROOT, order: r_ord + ORD_W'(1)};
                n_state    = mg_same ? S_MG_S : S_MG_C2;
            end

            S_MG_C2: begin
                o_bm.re    = 1'b1;
                o_bm.raddr = {r_ord, mg_r[FRAME_W-1:BIT_W]};
                n_state    = S_MG_C2W;
            end

            S_MG_C2W: begin
                o_bm.we    = 1'b1;
                o_bm.waddr = {r_ord, mg_r[FRAME_W-1:BIT_W]};
                o_bm.wd    = i_bm_rd & ~(WORD_BITS'(1) << mg_r[BIT_W-1:0]);
                n_state    = S_MG_S;
            end

            // Merge: add the joined block one order up
            S_MG_S: begin
                o_bm.re    = 1'b1;
                o_bm.raddr = {r_ord + ORD_W'(1), mg_l[FRAME_W-1:BIT_W]};
                n_state    = S_MG_SW;
            end

            S_MG_SW: begin
                o_bm.we    = 1'b1;
                o_bm.waddr = {r_ord + ORD_W'(1), mg_l[FRAME_W-1:BIT_W]};
                o_bm.wd    = i_bm_rd | (WORD_BITS'(1) << mg_l[BIT_W-1:0]);
                n_pos      = mg_l;
                n_ord      = r_ord + ORD_W'(1);
                n_state    = S_MG_TOP;
            end

            // Hand the result to the output register
            S_RESP: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Drive the result and the input stall
    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_res.valid  = (r_state == S_RESP);
        o_res.status = r_status;
        o_res.frame  = r_frame;
        o_res.order  = r_order;
    end

endmodule

`default_nettype wire

FILE: sv/buddy_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page frame allocator
// Power-of-two frame blocks over a 64K-frame space, kept in a frame table and
// a per-order free bitmap.
// ----------------------------------------------------------------------------
// Usage: one request channel (i_in_valid / o_in_stall, fields i_kind,
// i_first_frame, i_last_frame, i_frames_wanted) and one result channel
// (o_out_valid / i_out_stall, fields o_status, o_frame_index, o_block_order).
// Every request gives exactly one result. Requests run one at a time; the
// next is taken while the previous result still waits in the output register.
// Each request runs as read-modify-write steps on the two memories, one
// registered read per step:
//   reserve  : marks each frame of the range in turn
//   build    : checks each buddy pair over all levels, then each frame
//   allocate : scans bitmap words (up to 20480 words), then splits once
//              per split level
//   free     : checks and frees the frame, then merges level by level
// After reset the block sweeps both memories and stalls requests until
// that sweep is over. A stalled result holds in the output
// register; the sequencer waits with the next result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_frame_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_first_frame,
    input  wire logic [15:0] i_last_frame,
    input  wire logic [16:0] i_frames_wanted,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_frame_index,
    output logic [4:0]       o_block_order
);
    import bpfa_pkg::*;

    t_frm_req             frm_req;
    t_frame_ent           frm_rda;
    t_frame_ent           frm_rdb;
    t_bm_req              bm_req;
    logic [WORD_BITS-1:0] bm_rd;
    t_res                 res;
    logic                 res_take;

    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [FRAME_W-1:0]   r_frame;
    logic [ORD_W-1:0]     r_order;

    bpfa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_first_frame  (i_first_frame),
        .i_last_frame   (i_last_frame),
        .i_frames_wanted(i_frames_wanted),
        .o_frm          (frm_req),
        .i_frm_rda      (frm_rda),
        .i_frm_rdb      (frm_rdb),
        .o_bm           (bm_req),
        .i_bm_rd        (bm_rd),
        .o_res          (res),
        .i_res_take     (res_take)
    );

    bpfa_frame_mem u_frame_mem (
        .i_clk(i_clk),
        .i_req(frm_req),
        .o_rda(frm_rda),
        .o_rdb(frm_rdb)
    );

    bpfa_bitmap_mem u_bitmap_mem (
        .i_clk(i_clk),
        .i_req(bm_req),
        .o_rd (bm_rd)
    );

    // Take a new result when the output register is empty or draining
    assign res_take = !r_out_valid || !i_out_stall;

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res.valid) begin
            r_status <= res.status;
            r_frame  <= res.frame;
            r_order  <= res.order;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_frame_index = r_frame;
    assign o_block_order = r_order;

endmodule

`default_nettype wire

FILE: sv/bpfa_checker.sv
// ----------------------------------------------------------------------------
// Buddy page frame allocator: port checker
// Watches the top-level ports over time and flags broken results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_page_frame_allocator_assert.svh"

module bpfa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [1:0]  i_kind,
    input wire logic [15:0] i_first_frame,
    input wire logic [15:0] i_last_frame,
    input wire logic [16:0] i_frames_wanted,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_frame_index,
    input wire logic [4:0]  o_block_order
);
    import bpfa_pkg::*;

    // A stalled result holds
    `BPFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall), (o_out_valid && $stable(o_status) && $stable(o_frame_index) && $stable(o_block_order)))

    // One request at a time: the channel closes after each accept
    `BPFA_ASSERT_NEXT(a_one_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall), o_in_stall)

    // A failed or rejected request carries no frame and no order
    `BPFA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, (o_out_valid && o_status != STAT_DONE), (o_frame_index == 16'd0 && o_block_order == 5'd0))

    // A granted block is aligned to its own size
    `BPFA_ASSERT_IMPL(a_aligned, i_clk, i_rst_n, o_out_valid, ((o_frame_index & ((16'd1 << o_block_order) - 16'd1)) == 16'd0))

endmodule

bind buddy_page_frame_allocator bpfa_checker u_bpfa_checker (.*);

`default_nettype wire
